/* sv/fractional_n_pll_word_calc_assert.svh */
// Assertion macros for the synthesizer divider word calculator.
`ifndef FRACTIONAL_N_PLL_WORD_CALC_ASSERT_SVH
`define FRACTIONAL_N_PLL_WORD_CALC_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define FNPW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define FNPW_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define FNPW_ASSERT(lbl, prop, msg)
`define FNPW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/fnpw_pkg.sv */
// Shared types, constants and band tables of the divider word calculator.
package fnpw_pkg;

   localparam int unsigned XO_W    = 26;
   localparam int unsigned FREQ_W  = 32;
   localparam int unsigned STEP_W  = 25;
   localparam int unsigned FIELD_FRAC_W = 19;
   localparam logic [FREQ_W-1:0] B0_LO = 32'd850000000;
   localparam logic [FREQ_W-1:0] B0_HI = 32'd1050000000;
   localparam logic [FREQ_W-1:0] B1_LO = 32'd420000000;
   localparam logic [FREQ_W-1:0] B1_HI = 32'd525000000;
   localparam logic [FREQ_W-1:0] B2_LO = 32'd284000000;
   localparam logic [FREQ_W-1:0] B2_HI = 32'd350000000;
   localparam logic [FREQ_W-1:0] B3_LO = 32'd142000000;
   localparam logic [FREQ_W-1:0] B3_HI = 32'd175000000;
   localparam logic [XO_W-1:0] XO_RESET = 26'd30000000;
   // ceil(2^26/3): exact floor(x/3) for any x below 2^25
   localparam int unsigned RECIP3_SHIFT = 26;
   localparam logic [STEP_W-1:0] RECIP3 = 25'd22369622;

   typedef enum logic [1:0] {
      BAND_DIV4  = 2'd0,
      BAND_DIV8  = 2'd1,
      BAND_DIV12 = 2'd2,
      BAND_DIV24 = 2'd3
   } band_type;

   typedef struct packed {
      logic in_band;
      band_type band;
      logic [4:0] divider;
   } band_sel_type;

   typedef struct packed {
      band_sel_type sel;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] rem;
      logic [FREQ_W-1:0] dvd;
   } cell_data_type;

   function automatic band_sel_type pick_band(input logic [FREQ_W-1:0] f);
      band_sel_type s;
      s = '{in_band: 1'b0, band: BAND_DIV4, divider: 5'd0};
      priority if (f > B0_LO && f < B0_HI) begin
         s = '{in_band: 1'b1, band: BAND_DIV4, divider: 5'd4};
      end else if (f > B1_LO && f < B1_HI) begin
         s = '{in_band: 1'b1, band: BAND_DIV8, divider: 5'd8};
      end else if (f > B2_LO && f < B2_HI) begin
         s = '{in_band: 1'b1, band: BAND_DIV12, divider: 5'd12};
      end else if (f > B3_LO && f < B3_HI) begin
         s = '{in_band: 1'b1, band: BAND_DIV24, divider: 5'd24};
      end else begin
         s = '{in_band: 1'b0, band: BAND_DIV4, divider: 5'd0};
      end
      return s;
   endfunction

   function automatic logic [3:0] vco_adjust(input band_type b);
      logic [3:0] v;
      unique case (b)
         BAND_DIV4:  v = 4'hF;
         BAND_DIV8:  v = 4'hE;
         BAND_DIV12: v = 4'hD;
         BAND_DIV24: v = 4'hA;
         default:    v = 4'h0;
      endcase
      return v;
   endfunction

   function automatic logic [17:0] if_setting(input band_type b);
      logic [17:0] v;
      unique case (b)
         BAND_DIV4:  v = 18'h3C000;
         BAND_DIV8:  v = 18'h38000;
         BAND_DIV12: v = 18'h34000;
         BAND_DIV24: v = 18'h28000;
         default:    v = 18'h0;
      endcase
      return v;
   endfunction

endpackage

/* sv/fnpw_div_cell.sv */
// One restoring division cell: develops one quotient bit per item.
module fnpw_div_cell import fnpw_pkg::*; #(
   parameter int unsigned QUO_W = 27
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   output logic                ready_o,
   input  cell_data_type       data_i,
   input  logic [QUO_W-1:0]    quo_i,
   output logic                valid_o,
   input  logic                ready_i,
   output cell_data_type       data_o,
   output logic [QUO_W-1:0]    quo_o
);

   logic              valid_ff;
   cell_data_type     data_ff, data_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W:0]   trial;
   logic              fits;

   assign ready_o = !valid_ff || ready_i;

   always_comb begin
      trial   = {data_i.rem, data_i.dvd[FREQ_W-1]};
      fits    = trial >= {1'b0, data_i.step};
      data_in = data_i;
      data_in.dvd = {data_i.dvd[FREQ_W-2:0], 1'b0};
      if (fits) begin
         data_in.rem = STEP_W'(trial - {1'b0, data_i.step});
      end else begin
         data_in.rem = trial[STEP_W-1:0];
      end
      quo_in = {quo_i[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o) begin
         data_ff <= data_in;
         quo_ff  <= quo_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;
   assign quo_o   = quo_ff;

endmodule

/* sv/fnpw_front.sv */
// Band pick and PLL step (2*crystal/divider) ahead of the divider row.
module fnpw_front import fnpw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [XO_W-1:0]     crystal_hz,
   input  logic                valid_i,
   output logic                ready_o,
   input  logic [FREQ_W-1:0]   target_hz,
   output logic                valid_o,
   input  logic                ready_i,
   output cell_data_type       data_o
);

   logic                 a_valid_ff, b_valid_ff;
   logic                 a_ready, b_ready;
   band_sel_type         a_sel_ff;
   logic [FREQ_W-1:0]    a_freq_ff;
   cell_data_type        b_data_ff, b_data_in;
   logic [STEP_W-1:0]    base;
   logic [2*STEP_W-1:0]  prod;

   assign b_ready = !b_valid_ff || ready_i;
   assign a_ready = !a_valid_ff || b_ready;
   assign ready_o = a_ready;

   always_comb begin
      // 2*xo/4 and 2*xo/8 are shifts; the /12 and /24 bands add a /3
      if (a_sel_ff.band == BAND_DIV4 || a_sel_ff.band == BAND_DIV12) begin
         base = crystal_hz[XO_W-1:1];
      end else begin
         base = {1'b0, crystal_hz[XO_W-1:2]};
      end
      prod = base * RECIP3;
      b_data_in.sel = a_sel_ff;
      b_data_in.rem = '0;
      b_data_in.dvd = a_freq_ff;
      if (!a_sel_ff.in_band) begin
         b_data_in.step = '0;
      end else if (a_sel_ff.band == BAND_DIV12 || a_sel_ff.band == BAND_DIV24) begin
         b_data_in.step = STEP_W'(prod >> RECIP3_SHIFT);
      end else begin
         b_data_in.step = base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= valid_i;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_sel_ff  <= pick_band(target_hz);
         a_freq_ff <= target_hz;
      end
      if (b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign valid_o = b_valid_ff;
   assign data_o  = b_data_ff;

endmodule

/* sv/fractional_n_pll_word_calc.sv */
// Fractional-N synthesizer divider word calculator, top level.
// Takes one target frequency per cycle while the output drains and returns one
// result per item, in order. The path has two front stages for band pick and step,
// one divider cell per quotient bit of target*2^FRACTION_BITS over the step
// (32 + FRACTION_BITS cells), and one output register. Each cell holds one item,
// so the row takes a new item every cycle when the output drains.
`include "fractional_n_pll_word_calc_assert.svh"
module fractional_n_pll_word_calc import fnpw_pkg::*; #(
   parameter int unsigned FRACTION_BITS = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [25:0]         csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_target_hz,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_in_band,
   output logic [1:0]          rsp_band_index,
   output logic [4:0]          rsp_output_divider,
   output logic [7:0]          rsp_integer_word,
   output logic [18:0]         rsp_fraction_word,
   output logic signed [3:0]   rsp_vco_count_adjust,
   output logic [17:0]         rsp_if_word
);

   localparam int unsigned NCELL = FREQ_W + FRACTION_BITS;
   localparam int unsigned QUO_W = 8 + FRACTION_BITS;

   logic [XO_W-1:0]     crystal_ff;
   logic                chain_valid [NCELL+1];
   logic                chain_ready [NCELL+1];
   cell_data_type       chain_data  [NCELL+1];
   logic [QUO_W-1:0]    chain_quo   [NCELL+1];

   logic                out_valid_ff, out_ready;
   logic                in_band_ff, in_band_in;
   logic [1:0]          band_ff, band_in;
   logic [4:0]          div_ff, div_in;
   logic [7:0]          int_ff, int_in;
   logic [18:0]         frac_ff, frac_in;
   logic [3:0]          vco_ff, vco_in;
   logic [17:0]         ifw_ff, ifw_in;
   cell_data_type       last;
   logic [QUO_W-1:0]    last_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff <= XO_RESET;
      end else if (csr_wr_en) begin
         crystal_ff <= csr_wr_data;
      end
   end

   fnpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .crystal_hz (crystal_ff),
      .valid_i    (req_valid),
      .ready_o    (req_ready),
      .target_hz  (req_target_hz),
      .valid_o    (chain_valid[0]),
      .ready_i    (chain_ready[0]),
      .data_o     (chain_data[0])
   );

   assign chain_quo[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      fnpw_div_cell #(.QUO_W(QUO_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (chain_valid[k]),
         .ready_o (chain_ready[k]),
         .data_i  (chain_data[k]),
         .quo_i   (chain_quo[k]),
         .valid_o (chain_valid[k+1]),
         .ready_i (chain_ready[k+1]),
         .data_o  (chain_data[k+1]),
         .quo_o   (chain_quo[k+1])
      );
   end

   assign out_ready          = !out_valid_ff || rsp_ready;
   assign chain_ready[NCELL] = out_ready;
   assign last               = chain_data[NCELL];
   assign last_quo           = chain_quo[NCELL];

   always_comb begin
      in_band_in = last.sel.in_band;
      band_in    = '0;
      div_in     = '0;
      int_in     = '0;
      frac_in    = '0;
      vco_in     = '0;
      ifw_in     = '0;
      if (last.sel.in_band) begin
         band_in = last.sel.band;
         div_in  = last.sel.divider;
         vco_in  = vco_adjust(last.sel.band);
         ifw_in  = if_setting(last.sel.band);
         // zero step: leave both divide words at zero
         if (last.step != '0) begin
            int_in  = last_quo[QUO_W-1 -: 8] - 8'd1;
            frac_in = FIELD_FRAC_W'(last_quo[FRACTION_BITS-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= chain_valid[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         in_band_ff <= in_band_in;
         band_ff    <= band_in;
         div_ff     <= div_in;
         int_ff     <= int_in;
         frac_ff    <= frac_in;
         vco_ff     <= vco_in;
         ifw_ff     <= ifw_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_in_band          = in_band_ff;
   assign rsp_band_index       = band_ff;
   assign rsp_output_divider   = div_ff;
   assign rsp_integer_word     = int_ff;
   assign rsp_fraction_word    = frac_ff;
   assign rsp_vco_count_adjust = signed'(vco_ff);
   assign rsp_if_word          = ifw_ff;

   `FNPW_ASSERT(a_out_of_band_zero, rsp_valid && !rsp_in_band |-> rsp_band_index == 2'd0 && rsp_output_divider == 5'd0 && rsp_integer_word == 8'd0 && rsp_fraction_word == 19'd0 && rsp_if_word == 18'd0, "out of band result carries nonzero fields")
   `FNPW_ASSERT(a_divider_matches_band, rsp_valid && rsp_in_band |-> (rsp_band_index == BAND_DIV4 && rsp_output_divider == 5'd4) || (rsp_band_index == BAND_DIV8 && rsp_output_divider == 5'd8) || (rsp_band_index == BAND_DIV12 && rsp_output_divider == 5'd12) || (rsp_band_index == BAND_DIV24 && rsp_output_divider == 5'd24), "divider does not match band index")
   `FNPW_ASSERT_ALWAYS(a_reset_clears_output, reset |=> !rsp_valid, "result valid right after reset")

endmodule
